// ----- rtl/lru_list_with_pinned_entries_defines.svh -----
// Assertion helpers; expect clk and rst in scope.
`ifndef LRU_LIST_WITH_PINNED_ENTRIES_DEFINES_SVH
`define LRU_LIST_WITH_PINNED_ENTRIES_DEFINES_SVH

// Same-cycle implication.
`define LRU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LRU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lru_pkg.sv -----
`timescale 1ns / 1ps

package lru_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int ID_BITS_DEF  = 16;
  localparam int ID_W         = 16;
  localparam int FUNC_W       = 3;
  localparam int LIMIT_W      = 5;
  localparam int STATUS_W     = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_TOUCH  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_LOCK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_UNLOCK = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EVICT
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_COMPARE,
    OP_TOP,
    OP_APPEND,
    OP_DROP_HIT,
    OP_DROP_FREE,
    OP_LOCK
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     lock;
  } cell_ctrl_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   entry_id;
  } req_t;

  typedef struct packed {
    logic                evicted_valid;
    logic [ID_W-1:0]     evicted_id;
    logic [STATUS_W-1:0] status;
    logic                last;
  } rsp_t;

endpackage

// ----- rtl/lru_slot.sv -----
`timescale 1ns / 1ps

module lru_slot #(
  parameter int ID_BITS = lru_pkg::ID_BITS_DEF,
  parameter int CNT_W   = 5,
  parameter int IDX     = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  lru_pkg::cell_ctrl_t ctrl,
  input  logic [ID_BITS-1:0] cmd_id,
  input  logic [CNT_W-1:0]   count,
  input  logic [CNT_W-1:0]   top_idx,
  input  logic [ID_BITS-1:0] up_id,
  input  logic               up_valid,
  input  logic               up_locked,
  output logic [ID_BITS-1:0] id,
  output logic               valid,
  output logic               locked,
  input  logic               fseen_in,
  output logic               fseen_out,
  input  logic [ID_BITS-1:0] fid_in,
  output logic [ID_BITS-1:0] fid_out,
  input  logic               hseen_in,
  output logic               hseen_out,
  input  logic               hlock_in,
  output logic               hlock_out
);

  logic hit;
  logic cand;
  logic is_cnt;
  logic is_top;

  assign cand   = valid && !locked;
  assign is_cnt = (count == CNT_W'(IDX));
  assign is_top = (top_idx == CNT_W'(IDX));

  // lowest free slot and lowest hit ripple upward
  always_comb begin
    fseen_out = fseen_in | cand;
    fid_out   = (cand && !fseen_in) ? id : fid_in;
    hseen_out = hseen_in | hit;
    hlock_out = hlock_in | (hit & locked);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      locked <= 1'b0;
      hit    <= 1'b0;
    end else begin
      unique case (ctrl.op)
        lru_pkg::OP_HOLD: begin
        end
        lru_pkg::OP_COMPARE: begin
          hit <= valid && (id == cmd_id);
        end
        lru_pkg::OP_TOP: begin
          if (is_top) begin
            id     <= cmd_id;
            locked <= ctrl.lock;
          end else if (hseen_out) begin
            id     <= up_id;
            valid  <= up_valid;
            locked <= up_locked;
          end
        end
        lru_pkg::OP_APPEND: begin
          if (is_cnt) begin
            id     <= cmd_id;
            valid  <= 1'b1;
            locked <= 1'b0;
          end
        end
        lru_pkg::OP_DROP_HIT: begin
          if (hseen_out) begin
            id     <= up_id;
            valid  <= up_valid;
            locked <= up_locked;
          end
        end
        lru_pkg::OP_DROP_FREE: begin
          if (fseen_out) begin
            id     <= up_id;
            valid  <= up_valid;
            locked <= up_locked;
          end
        end
        lru_pkg::OP_LOCK: begin
          if (hit) begin
            locked <= ctrl.lock;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/lru_list_with_pinned_entries.sv -----
`timescale 1ns / 1ps
// Slots compare in the accept cycle; S_EXEC and S_EVICT decide and register results.
// Each eviction adds one result; a touch that evicts first moves its hit to the top.
// Throughput: no new request is taken while busy; one slot-chain
// match, shift or eviction per cycle. Results cannot be held off by the receiver.
// Reset: slots empty, unlocked, count zero, limit 16; stored ids are not cleared.
`include "lru_list_with_pinned_entries_defines.svh"

module lru_list_with_pinned_entries #(
  parameter int CAPACITY = lru_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = lru_pkg::ID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  lru_pkg::req_t                 req,
  input  logic                          cfg_we,
  input  logic [lru_pkg::LIMIT_W-1:0]   cfg_wdata,
  output logic                          rsp_strobe,
  output lru_pkg::rsp_t                 rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > lru_pkg::LIMIT_W) ? CNT_W : lru_pkg::LIMIT_W;
  localparam int OID_W = lru_pkg::ID_W;

  lru_pkg::state_t     state;
  lru_pkg::state_t     state_next;
  logic [lru_pkg::FUNC_W-1:0] func_r;
  logic [ID_BITS-1:0]  id_r;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    cnt_next;
  logic [lru_pkg::LIMIT_W-1:0] limit;
  logic                evict_ins;

  lru_pkg::cell_ctrl_t ctrl;
  logic [ID_BITS-1:0]  cmd_id;
  logic [ID_BITS-1:0]  req_id;
  logic [CNT_W-1:0]    top_idx;
  logic                emit;
  lru_pkg::rsp_t       rsp_next;

  logic [ID_BITS-1:0]  slot_id     [CAPACITY+1];
  logic                slot_valid  [CAPACITY+1];
  logic                slot_locked [CAPACITY+1];
  logic                fseen [CAPACITY+1];
  logic [ID_BITS-1:0]  fid   [CAPACITY+1];
  logic                hseen [CAPACITY+1];
  logic                hlock [CAPACITY+1];

  logic [CMP_W-1:0] lim_ext;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] lim_eff;
  logic [CMP_W-1:0] cnt_ext;
  logic found, any_free, lim_zero, over_ins, over_tch;
  logic ins_absent, touch_path, in_ins, can_evict, accept;

  assign accept  = start && !busy;
  assign busy    = (state != lru_pkg::S_IDLE);
  assign req_id  = ID_BITS'(req.entry_id);
  assign cmd_id  = (state == lru_pkg::S_IDLE) ? req_id : id_r;
  assign top_idx = cnt - CNT_W'(1);

  assign slot_id[CAPACITY]     = '0;
  assign slot_valid[CAPACITY]  = 1'b0;
  assign slot_locked[CAPACITY] = 1'b0;
  assign fseen[0] = 1'b0;
  assign fid[0]   = '0;
  assign hseen[0] = 1'b0;
  assign hlock[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    lru_slot #(
      .ID_BITS (ID_BITS),
      .CNT_W   (CNT_W),
      .IDX     (i)
    ) u_slot (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .cmd_id    (cmd_id),
      .count     (cnt),
      .top_idx   (top_idx),
      .up_id     (slot_id[i+1]),
      .up_valid  (slot_valid[i+1]),
      .up_locked (slot_locked[i+1]),
      .id        (slot_id[i]),
      .valid     (slot_valid[i]),
      .locked    (slot_locked[i]),
      .fseen_in  (fseen[i]),
      .fseen_out (fseen[i+1]),
      .fid_in    (fid[i]),
      .fid_out   (fid[i+1]),
      .hseen_in  (hseen[i]),
      .hseen_out (hseen[i+1]),
      .hlock_in  (hlock[i]),
      .hlock_out (hlock[i+1])
    );
  end

  assign lim_ext  = CMP_W'(limit);
  assign cap_ext  = CMP_W'(CAPACITY);
  assign lim_eff  = (lim_ext > cap_ext) ? cap_ext : lim_ext;
  assign cnt_ext  = CMP_W'(cnt);
  assign lim_zero = (lim_eff == '0);
  assign over_ins = (cnt_ext >= lim_eff);
  assign over_tch = (cnt_ext > lim_eff);
  assign found    = hseen[CAPACITY];
  assign any_free = fseen[CAPACITY];

  assign ins_absent = (func_r == lru_pkg::FN_INSERT) && !found;
  assign touch_path = ((func_r == lru_pkg::FN_INSERT) || (func_r == lru_pkg::FN_TOUCH))
                      && found;
  assign in_ins     = (state == lru_pkg::S_EXEC) ? ins_absent : evict_ins;
  assign can_evict  = (in_ins ? over_ins : over_tch) && any_free;

  always_comb begin
    state_next = state;
    unique case (state)
      lru_pkg::S_IDLE: begin
        if (start) state_next = lru_pkg::S_EXEC;
      end
      lru_pkg::S_EXEC: begin
        if (ins_absent && !lim_zero && can_evict) state_next = lru_pkg::S_EVICT;
        else if (touch_path && over_tch) state_next = lru_pkg::S_EVICT;
        else state_next = lru_pkg::S_IDLE;
      end
      lru_pkg::S_EVICT: begin
        state_next = can_evict ? lru_pkg::S_EVICT : lru_pkg::S_IDLE;
      end
      default: state_next = lru_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.op  = lru_pkg::OP_HOLD;
    ctrl.lock = 1'b0;
    cnt_next = cnt;
    emit     = 1'b0;
    rsp_next = '0;
    rsp_next.last   = 1'b1;
    rsp_next.status = lru_pkg::STAT_DONE;
    unique case (state)
      lru_pkg::S_IDLE: begin
        emit = 1'b0;
        if (start) ctrl.op = lru_pkg::OP_COMPARE;
      end
      lru_pkg::S_EXEC, lru_pkg::S_EVICT: begin
        priority if ((state == lru_pkg::S_EVICT) || (ins_absent && !lim_zero)) begin
          // one eviction step, or the closing append / reject
          emit = 1'b1;
          priority if (can_evict) begin
            ctrl.op  = lru_pkg::OP_DROP_FREE;
            cnt_next = cnt - CNT_W'(1);
            rsp_next.evicted_valid = 1'b1;
            rsp_next.evicted_id    = OID_W'(fid[CAPACITY]);
            rsp_next.last          = 1'b0;
          end else if (in_ins && over_ins) begin
            rsp_next.status = lru_pkg::STAT_REJECT;
          end else if (in_ins) begin
            ctrl.op  = lru_pkg::OP_APPEND;
            cnt_next = cnt + CNT_W'(1);
          end else begin
            rsp_next.status = lru_pkg::STAT_DONE;
          end
        end else if (ins_absent) begin
          emit = 1'b1;
          rsp_next.status = lru_pkg::STAT_REJECT;
        end else if (touch_path) begin
          ctrl.op   = lru_pkg::OP_TOP;
          ctrl.lock = hlock[CAPACITY];
          emit      = !over_tch;
        end else if (!found && ((func_r == lru_pkg::FN_TOUCH) ||
                                (func_r == lru_pkg::FN_REMOVE) ||
                                (func_r == lru_pkg::FN_LOCK) ||
                                (func_r == lru_pkg::FN_UNLOCK))) begin
          emit = 1'b1;
          rsp_next.status = lru_pkg::STAT_ABSENT;
        end else if (func_r == lru_pkg::FN_REMOVE) begin
          emit     = 1'b1;
          ctrl.op  = lru_pkg::OP_DROP_HIT;
          cnt_next = cnt - CNT_W'(1);
        end else if ((func_r == lru_pkg::FN_LOCK) || (func_r == lru_pkg::FN_UNLOCK)) begin
          emit      = 1'b1;
          ctrl.op   = lru_pkg::OP_LOCK;
          ctrl.lock = (func_r == lru_pkg::FN_LOCK);
        end else begin
          emit = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lru_pkg::S_IDLE;
      cnt        <= '0;
      limit      <= lru_pkg::LIMIT_RESET;
      rsp_strobe <= 1'b0;
      evict_ins  <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      rsp_strobe <= emit;
      if (cfg_we) limit <= cfg_wdata;
      if (state == lru_pkg::S_EXEC) evict_ins <= ins_absent;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
    if (accept) begin
      func_r <= req.func;
      id_r   <= req_id;
    end
  end

  `LRU_ASSERT_NXT(a_accept_exec, start && !busy, state == lru_pkg::S_EXEC, "no execute")
  `LRU_ASSERT_IMP(a_final_idle, rsp_strobe && rsp.last, state == lru_pkg::S_IDLE, "final busy")
  `LRU_ASSERT_IMP(a_evict_busy, rsp_strobe && !rsp.last, state == lru_pkg::S_EVICT, "stray evict")
  `LRU_ASSERT_IMP(a_count_bound, 1'b1, cnt_ext <= cap_ext, "entry count above capacity")

endmodule

// ----- tb/lru_list_with_pinned_entries_checker.sv -----
`timescale 1ns / 1ps

module lru_list_with_pinned_entries_checker
  import lru_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  req_t               req,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  logic               rsp_strobe,
  input  rsp_t               rsp,
  output int                 mismatches,
  output int                 outstanding
);

  // Shadow recency list, slot 0 least recent.
  logic [ID_W-1:0]    slot_id   [CAPACITY];
  bit                 slot_lock [CAPACITY];
  int                 fill;
  logic [LIMIT_W-1:0] limit_raw;
  rsp_t               due_rsp [$];
  rsp_t               head;

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t mismatch %s: expected %0h got %0h", $time, what, want, got);
    mismatches++;
  endtask

  function automatic int locate(logic [ID_W-1:0] id);
    for (int i = 0; i < fill; i++)
      if (slot_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void close_gap(int p);
    for (int i = p; i + 1 < fill; i++) begin
      slot_id[i]   = slot_id[i + 1];
      slot_lock[i] = slot_lock[i + 1];
    end
    fill--;
    slot_lock[fill] = 1'b0;
  endfunction

  function automatic void raise_to_mru(int p);
    logic [ID_W-1:0] id;
    bit              lk;
    id = slot_id[p];
    lk = slot_lock[p];
    for (int i = p; i + 1 < fill; i++) begin
      slot_id[i]   = slot_id[i + 1];
      slot_lock[i] = slot_lock[i + 1];
    end
    slot_id[fill - 1]   = id;
    slot_lock[fill - 1] = lk;
  endfunction

  function automatic bit take_victim(output logic [ID_W-1:0] id);
    id = '0;
    for (int i = 0; i < fill; i++) begin
      if (!slot_lock[i]) begin
        id = slot_id[i];
        close_gap(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void push_result(logic v, logic [ID_W-1:0] id,
                                      logic [STATUS_W-1:0] st, logic fin);
    rsp_t r;
    r.evicted_valid = v;
    r.evicted_id    = id;
    r.status        = st;
    r.last          = fin;
    due_rsp.push_back(r);
  endfunction

  function automatic void apply_request(req_t r);
    int                  p;
    int                  lim;
    logic [ID_W-1:0]     victim;
    logic [STATUS_W-1:0] st;
    bit                  stuck;
    p     = locate(r.entry_id);
    lim   = (int'(limit_raw) > CAPACITY) ? CAPACITY : int'(limit_raw);
    st    = STAT_DONE;
    stuck = 1'b0;
    if (r.func == FN_INSERT && p < 0) begin
      if (lim == 0) begin
        st = STAT_REJECT;
      end else begin
        while (fill >= lim && st == STAT_DONE) begin
          if (take_victim(victim)) push_result(1'b1, victim, STAT_DONE, 1'b0);
          else st = STAT_REJECT;
        end
        if (st == STAT_DONE && fill < CAPACITY) begin
          slot_id[fill]   = r.entry_id;
          slot_lock[fill] = 1'b0;
          fill++;
        end
      end
    end else if (r.func == FN_INSERT || r.func == FN_TOUCH) begin
      if (p < 0) begin
        st = STAT_ABSENT;
      end else begin
        raise_to_mru(p);
        while (fill > lim && !stuck) begin
          if (take_victim(victim)) push_result(1'b1, victim, STAT_DONE, 1'b0);
          else stuck = 1'b1;
        end
      end
    end else if (r.func == FN_REMOVE || r.func == FN_LOCK || r.func == FN_UNLOCK) begin
      if (p < 0) st = STAT_ABSENT;
      else if (r.func == FN_REMOVE) close_gap(p);
      else slot_lock[p] = (r.func == FN_LOCK);
    end
    push_result(1'b0, '0, st, 1'b1);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fill       = 0;
      limit_raw  = LIMIT_RESET;
      mismatches = 0;
      foreach (slot_lock[i]) slot_lock[i] = 1'b0;
      due_rsp.delete();
    end else begin
      if (rsp_strobe) begin
        if (due_rsp.size() == 0) begin
          report_mismatch("unexpected result", 32'h0, 32'(rsp));
        end else begin
          head = due_rsp.pop_front();
          if (rsp.evicted_valid !== head.evicted_valid)
            report_mismatch("evicted_valid", 32'(head.evicted_valid), 32'(rsp.evicted_valid));
          if (rsp.evicted_id !== head.evicted_id)
            report_mismatch("evicted_id", 32'(head.evicted_id), 32'(rsp.evicted_id));
          if (rsp.status !== head.status)
            report_mismatch("status", 32'(head.status), 32'(rsp.status));
          if (rsp.last !== head.last)
            report_mismatch("last", 32'(head.last), 32'(rsp.last));
        end
      end
      if (cfg_we) limit_raw = cfg_wdata;
      if (start && !busy) apply_request(req);
    end
    outstanding = due_rsp.size();
  end

endmodule

// ----- tb/lru_list_with_pinned_entries_tb.sv -----
`timescale 1ns / 1ps

module lru_list_with_pinned_entries_tb;
  import lru_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE   = 24;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 18;

  // Func codes the block ignores.
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  req_t               req;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;
  logic               rsp_strobe;
  rsp_t               rsp;
  int                 mismatches;
  int                 outstanding;
  int                 cycles = 0;
  bit                 burst;
  logic [ID_W-1:0]    id_pool [POOL_SIZE];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  lru_list_with_pinned_entries dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp_strobe(rsp_strobe),
    .rsp       (rsp)
  );

  lru_list_with_pinned_entries_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .rsp_strobe (rsp_strobe),
    .rsp        (rsp),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("lru_list_with_pinned_entries regression: fail");
      $finish;
    end
  end

  task automatic send(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id);
    @(negedge clk);
    start        = 1'b1;
    req.func     = f;
    req.entry_id = id;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic set_limit(logic [LIMIT_W-1:0] v);
    idle_for(1);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(int ins_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return FN_INSERT;
    r = $urandom_range(0, 99);
    if (r < 35) return FN_TOUCH;
    if (r < 55) return FN_REMOVE;
    if (r < 75) return FN_LOCK;
    if (r < 95) return FN_UNLOCK;
    return 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 99) < 85) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    logic [LIMIT_W-1:0] phase_limit [PHASES];
    int                 phase_ins   [PHASES];
    phase_limit = '{5'd31, 5'd1, 5'd16, 5'd3, 5'd0, 5'd8, 5'd2, 5'd16};
    phase_ins   = '{70, 40, 75, 40, 30, 45, 40, 50};
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    burst     = 1'b0;
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = 16'($urandom_range(0, 65535));
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send(FN_INSERT, 16'h0000);
    send(FN_INSERT, 16'hFFFF);
    send(FN_INSERT, 16'h1234);
    send(FN_INSERT, 16'hFFFF);  // present id, acts as touch
    send(FN_TOUCH,  16'h0000);
    send(FN_TOUCH,  16'hBEEF);  // absent
    send(FN_LOCK,   16'h1234);
    send(FN_LOCK,   16'h1234);
    send(FN_UNLOCK, 16'h1234);
    send(FN_UNLOCK, 16'h1234);
    send(FN_UNLOCK, 16'hBEEF);
    send(FN_REMOVE, 16'hFFFF);
    send(FN_REMOVE, 16'hFFFF);
    for (int f = FN_SPARE_LO; f <= FN_SPARE_HI; f++) send(3'(f), pick_id());
    send(FN_LOCK,   16'h0000);
    send(FN_INSERT, 16'h00AA);
    send(FN_LOCK,   16'h00AA);
    set_limit(5'd2);
    send(FN_INSERT, 16'h5555);  // one eviction, then all locked: rejected
    set_limit(5'd1);
    send(FN_TOUCH,  16'h0000);  // above limit, all locked
    set_limit(5'd0);
    send(FN_INSERT, 16'h7777);  // zero limit
    set_limit(5'd31);
    send(FN_UNLOCK, 16'h0000);
    send(FN_UNLOCK, 16'h00AA);

    for (int ph = 0; ph < PHASES; ph++) begin
      set_limit(phase_limit[ph]);
      burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        idle_for(pick_gap());
        send(pick_func(phase_ins[ph]), pick_id());
      end
    end

    idle_for(1);
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("lru_list_with_pinned_entries regression: pass");
    else
      $display("lru_list_with_pinned_entries regression: fail");
    $finish;
  end

endmodule
